@@ hw/rtl/tlps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlps_pkg
// Shared types and constants for the traffic light phase sequencer.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned QUART_W = LEN_W - 2;
  localparam int unsigned BITS_W  = 4;

  localparam logic [PHASE_W-1:0] PH_GREEN      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_GREEN_BLINK = 3'd1;
  localparam logic [PHASE_W-1:0] PH_YELLOW     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RED        = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RED_YELLOW = 3'd4;

  localparam logic [IDX_W-1:0] REG_GREEN       = 3'd0;
  localparam logic [IDX_W-1:0] REG_GREEN_BLINK = 3'd1;
  localparam logic [IDX_W-1:0] REG_YELLOW      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RED         = 3'd3;
  localparam logic [IDX_W-1:0] REG_RED_YELLOW  = 3'd4;

  localparam logic [LEN_W-1:0] RST_GREEN       = 16'd10000;
  localparam logic [LEN_W-1:0] RST_GREEN_BLINK = 16'd2000;
  localparam logic [LEN_W-1:0] RST_YELLOW      = 16'd2000;
  localparam logic [LEN_W-1:0] RST_RED         = 16'd10000;
  localparam logic [LEN_W-1:0] RST_RED_YELLOW  = 16'd2000;

  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic mod_init;
    logic mod_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_blink;
    logic scan_last;
    logic q_zero;
    logic mod_last;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/tlps_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlps_ctrl
// Sequencer: accepts a request, walks the phase scan and the blink modulo,
// then commits the result into the output register.
// ----------------------------------------------------------------------------
module tlps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire tlps_pkg::status_t status,
  output tlps_pkg::cmd_t        cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_hit) begin
          if (status.scan_blink && !status.q_zero) begin
            cmd.mod_init = 1'b1;
            state_next   = S_MOD;
          end else begin
            state_next = S_DONE;
          end
        end else if (status.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tlps_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlps_datapath
// Phase length registers, running-sum phase scan, bit-serial blink modulo,
// lamp state and output register.
// ----------------------------------------------------------------------------
module tlps_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tlps_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [tlps_pkg::LEN_W-1:0]    cfg_data,
  input  wire logic [tlps_pkg::TIME_W-1:0]   elapsed_ms,
  input  wire tlps_pkg::cmd_t                cmd,
  output tlps_pkg::status_t                  status,
  output logic                               green_on,
  output logic                               yellow_on,
  output logic                               red_on,
  output logic [tlps_pkg::PHASE_W-1:0]       phase
);

  logic [tlps_pkg::LEN_W-1:0]   green_ms;
  logic [tlps_pkg::LEN_W-1:0]   green_blink_ms;
  logic [tlps_pkg::LEN_W-1:0]   yellow_ms;
  logic [tlps_pkg::LEN_W-1:0]   red_ms;
  logic [tlps_pkg::LEN_W-1:0]   red_yellow_ms;

  logic [tlps_pkg::TIME_W-1:0]  t;
  logic [tlps_pkg::SUM_W-1:0]   sum;
  logic [tlps_pkg::SUM_W-1:0]   sum_next;
  logic [tlps_pkg::PHASE_W-1:0] k;
  logic [tlps_pkg::PHASE_W-1:0] cur_phase;
  logic [tlps_pkg::LEN_W-1:0]   len_sel;

  logic [tlps_pkg::TIME_W-1:0]  into_full;
  logic [tlps_pkg::QUART_W-1:0] q;
  logic [tlps_pkg::LEN_W-1:0]   dividend;
  logic [tlps_pkg::QUART_W-1:0] rem;
  logic [tlps_pkg::QUART_W:0]   rem_shift;
  logic [tlps_pkg::QUART_W:0]   rem_diff;
  logic [tlps_pkg::BITS_W-1:0]  bit_cnt;
  logic                         blink_green;

  logic lamp_green;
  logic lamp_yellow;
  logic lamp_red;
  logic lamp_green_next;
  logic lamp_yellow_next;
  logic lamp_red_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_ms       <= tlps_pkg::RST_GREEN;
      green_blink_ms <= tlps_pkg::RST_GREEN_BLINK;
      yellow_ms      <= tlps_pkg::RST_YELLOW;
      red_ms         <= tlps_pkg::RST_RED;
      red_yellow_ms  <= tlps_pkg::RST_RED_YELLOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlps_pkg::REG_GREEN:       green_ms       <= cfg_data;
        tlps_pkg::REG_GREEN_BLINK: green_blink_ms <= cfg_data;
        tlps_pkg::REG_YELLOW:      yellow_ms      <= cfg_data;
        tlps_pkg::REG_RED:         red_ms         <= cfg_data;
        tlps_pkg::REG_RED_YELLOW:  red_yellow_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (k)
      tlps_pkg::PH_GREEN:       len_sel = green_ms;
      tlps_pkg::PH_GREEN_BLINK: len_sel = green_blink_ms;
      tlps_pkg::PH_YELLOW:      len_sel = yellow_ms;
      tlps_pkg::PH_RED:         len_sel = red_ms;
      tlps_pkg::PH_RED_YELLOW:  len_sel = red_yellow_ms;
      default:                  len_sel = '0;
    endcase
  end

  assign sum_next  = sum + {{(tlps_pkg::SUM_W-tlps_pkg::LEN_W){1'b0}}, len_sel};
  assign into_full = t - {{(tlps_pkg::TIME_W-tlps_pkg::LEN_W){1'b0}}, green_ms};
  assign q         = green_blink_ms[tlps_pkg::LEN_W-1:2];
  assign rem_shift = {rem, dividend[tlps_pkg::LEN_W-1]};
  assign rem_diff  = rem_shift - {1'b0, q};

  assign status.scan_hit   = t < {{(tlps_pkg::TIME_W-tlps_pkg::SUM_W){1'b0}}, sum_next};
  assign status.scan_blink = (k == tlps_pkg::PH_GREEN_BLINK);
  assign status.scan_last  = (k == tlps_pkg::PH_RED_YELLOW);
  assign status.q_zero     = (q == '0);
  assign status.mod_last   = (bit_cnt == {tlps_pkg::BITS_W{1'b1}});

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t         <= elapsed_ms;
      sum       <= '0;
      k         <= '0;
      cur_phase <= tlps_pkg::PH_GREEN;
    end else if (cmd.scan_step) begin
      sum <= sum_next;
      k   <= k + 3'd1;
      if (status.scan_hit) begin
        cur_phase <= k;
      end
    end
    if (cmd.mod_init) begin
      dividend <= into_full[tlps_pkg::LEN_W-1:0];
      rem      <= '0;
      bit_cnt  <= '0;
    end else if (cmd.mod_step) begin
      dividend <= {dividend[tlps_pkg::LEN_W-2:0], 1'b0};
      bit_cnt  <= bit_cnt + 4'd1;
      if (!rem_diff[tlps_pkg::QUART_W]) begin
        rem <= rem_diff[tlps_pkg::QUART_W-1:0];
      end else begin
        rem <= rem_shift[tlps_pkg::QUART_W-1:0];
      end
    end
  end

  assign blink_green = status.q_zero || !(rem < {1'b0, q[tlps_pkg::QUART_W-1:1]});

  always_comb begin
    lamp_green_next  = lamp_green;
    lamp_yellow_next = lamp_yellow;
    lamp_red_next    = lamp_red;
    unique case (cur_phase)
      tlps_pkg::PH_GREEN: begin
        lamp_red_next    = 1'b0;
        lamp_yellow_next = 1'b0;
        lamp_green_next  = 1'b1;
      end
      tlps_pkg::PH_GREEN_BLINK: begin
        lamp_green_next = blink_green;
      end
      tlps_pkg::PH_YELLOW: begin
        lamp_green_next  = 1'b0;
        lamp_yellow_next = 1'b1;
      end
      tlps_pkg::PH_RED: begin
        lamp_yellow_next = 1'b0;
        lamp_red_next    = 1'b1;
      end
      default: begin
        lamp_red_next    = 1'b1;
        lamp_yellow_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_green  <= 1'b0;
      lamp_yellow <= 1'b0;
      lamp_red    <= 1'b0;
    end else if (cmd.commit) begin
      lamp_green  <= lamp_green_next;
      lamp_yellow <= lamp_yellow_next;
      lamp_red    <= lamp_red_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      green_on  <= lamp_green_next;
      yellow_on <= lamp_yellow_next;
      red_on    <= lamp_red_next;
      phase     <= cur_phase;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/traffic_light_phase_sequencer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// traffic_light_phase_sequencer_unit
// Maps elapsed time within a signal cycle to a phase and lamp drives.
//
// Input channel: in_valid / in_stall with elapsed_ms. A request is taken
// when in_valid is high and in_stall is low; one request is in flight at a
// time and in_stall stays high until its result enters the output register.
// Output channel: out_valid / out_stall with green_on, yellow_on, red_on and
// phase, one result per request, held in an output register while stalled.
// The next request can be taken while a result waits in that register.
// Steps: accept; a scan with one running-sum compare per phase up to the hit
// or the last phase; a bit-serial modulo in the blinking-green phase when a
// quarter of its length is nonzero; commit once the output register is free.
// Configuration: cfg_we writes cfg_data into phase length register
// cfg_index (0 green .. 4 red-yellow); other indexes are ignored.
// Reset: default lengths, lamp state off (not lamp outputs), channels empty.
// ----------------------------------------------------------------------------
module traffic_light_phase_sequencer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tlps_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [tlps_pkg::LEN_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tlps_pkg::TIME_W-1:0]   elapsed_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               green_on,
  output logic                               yellow_on,
  output logic                               red_on,
  output logic [tlps_pkg::PHASE_W-1:0]       phase
);

  tlps_pkg::cmd_t    cmd;
  tlps_pkg::status_t status;

  tlps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlps_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .elapsed_ms (elapsed_ms),
    .cmd        (cmd),
    .status     (status),
    .green_on   (green_on),
    .yellow_on  (yellow_on),
    .red_on     (red_on),
    .phase      (phase)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after accept");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase <= tlps_pkg::PH_RED_YELLOW))
    else $error("phase code out of range");

  a_green_lamps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == tlps_pkg::PH_GREEN) |-> (green_on && !yellow_on && !red_on))
    else $error("green phase lamps wrong");

  a_yellow_lamps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == tlps_pkg::PH_YELLOW) |-> (!green_on && yellow_on))
    else $error("yellow phase lamps wrong");

endmodule
`default_nettype wire
